// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/str_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper ramp package
// Widths, codes, the result word type and the period clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package str_pkg;

  localparam int STEP_W     = 32;
  localparam int PER_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int CLK_W      = 28;
  localparam int PRE_W      = 16;
  localparam int RAMP_W     = 16;
  localparam int SPD_W      = CLK_W + FRAC_W;
  localparam int DVD_W      = 72;
  localparam int DSR_W      = 48;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  localparam logic [24:0] RAMP_NUM   = 25'd28672000;
  localparam logic [9:0]  RATE_SCALE = 10'd1000;
  localparam logic [62:0] DELTA_CAP  = 63'h4000_0000_0000_0000;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_RUN  = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  localparam logic [1:0] PHASE_UNSET = 2'd0;
  localparam logic [1:0] PHASE_ACCEL = 2'd1;
  localparam logic [1:0] PHASE_HOLD  = 2'd2;
  localparam logic [1:0] PHASE_DECEL = 2'd3;

  localparam logic [2:0] CFG_TCLK = 3'd0;
  localparam logic [2:0] CFG_PRE  = 3'd1;
  localparam logic [2:0] CFG_RAMP = 3'd2;
  localparam logic [2:0] CFG_FWD  = 3'd3;
  localparam logic [2:0] CFG_FAST = 3'd4;
  localparam logic [2:0] CFG_SLOW = 3'd5;

  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [PER_W-2:0] compare;
    logic             dir;
    logic             pen;
    logic [1:0]       mode;
    logic [1:0]       phase;
  } res_t;

  function automatic logic [PER_W-1:0] clamp_period(input logic [CLK_W-1:0] p,
                                                    input logic [PER_W-1:0] fast,
                                                    input logic [PER_W-1:0] slow);
    logic [CLK_W-1:0] r;
    r = p;
    if (r < CLK_W'(fast)) r = CLK_W'(fast);
    if (r > CLK_W'(slow)) r = CLK_W'(slow);
    return (r == '0) ? PER_W'(1) : r[PER_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/str_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module str_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [str_pkg::DVD_W-1:0] dividend_i,
  input  logic [str_pkg::DSR_W-1:0] divisor_i,
  input  logic [str_pkg::CNT_W-1:0] nbits_i,
  output logic                      done_o,
  output logic [str_pkg::DVD_W-1:0] quot_o
);
  import str_pkg::*;

  logic [DVD_W-1:0] dvd_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DSR_W:0]   trial;
  logic             ge;
  logic [DSR_W:0]   rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? (trial - {1'b0, dsr_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= nbits_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i << (CNT_W'(DVD_W) - nbits_i);
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= rem_d[DSR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ===== hw/rtl/str_core.sv =====
// ----------------------------------------------------------------------------
// Stepper ramp core
// Command sequencer, motion state and configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module str_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [str_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [str_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [str_pkg::STEP_W-1:0]     step_count_i,
  input  logic [str_pkg::CLK_W-1:0]      speed_hz_i,
  input  logic                           run_backward_i,
  input  logic                           slot_free_i,
  output logic                           res_valid_o,
  output str_pkg::res_t                  res_o
);
  import str_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DEC   = 4'd1;
  localparam logic [3:0] ST_FC    = 4'd2;
  localparam logic [3:0] ST_SEL   = 4'd3;
  localparam logic [3:0] ST_TGT   = 4'd4;
  localparam logic [3:0] ST_SSP   = 4'd5;
  localparam logic [3:0] ST_STP   = 4'd6;
  localparam logic [3:0] ST_RAMP  = 4'd7;
  localparam logic [3:0] ST_SCUR  = 4'd8;
  localparam logic [3:0] ST_STAR  = 4'd9;
  localparam logic [3:0] ST_SMIN  = 4'd10;
  localparam logic [3:0] ST_T1    = 4'd11;
  localparam logic [3:0] ST_DELTA = 4'd12;
  localparam logic [3:0] ST_PER   = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0] state_q, state_d;

  logic [CLK_W-1:0] tclk_q;
  logic [PRE_W-1:0] pre_q;
  logic [RAMP_W-1:0] maxr_q;
  logic fwd_q;
  logic [PER_W-1:0] fast_q, slow_q;

  logic [1:0] cmd_q, cmd_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [CLK_W-1:0] speed_q, speed_d;
  logic back_q, back_d;

  logic [1:0] mode_q, mode_d, phase_q, phase_d;
  logic dir_q, dir_d, up_q, up_d;
  logic [PER_W-1:0] cur_q, cur_d, tp_q, tp_d;
  logic [RAMP_W-1:0] ramp_q, ramp_d;
  logic [STEP_W-1:0] tgt_q, tgt_d, emit_q, emit_d, hold_q, hold_d;
  logic [CLK_W-1:0] fc_q, fc_d;
  logic [SPD_W-1:0] s_cur_q, s_cur_d, s_tp_q, s_tp_d, s_sp_q, s_sp_d;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DSR_W-1:0] div_dsr;
  logic [CNT_W-1:0] div_n;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  logic [PER_W-1:0] sp;
  logic [RAMP_W-1:0] maxr_eff, rt, ramp_t;
  logic [CLK_W-1:0] pq, pm1;
  logic [PER_W-1:0] per_res;
  logic [STEP_W-1:0] emit_inc, mag;
  logic [SPD_W-1:0] mn, dspd;
  logic [62:0] delta, next_spd;
  logic [46:0] hz;
  logic [DVD_W-1:0] spd_dvd;

  str_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .nbits_i    (div_n),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_comb begin
    sp       = clamp_period(CLK_W'(slow_q), fast_q, slow_q);
    maxr_eff = (maxr_q == '0) ? RAMP_W'(1) : maxr_q;
    rt       = (ramp_q == '0) ? RAMP_W'(1) : ramp_q;
    pq       = div_q[CLK_W-1:0];
    pm1      = (pq == '0) ? '0 : pq - CLK_W'(1);
    per_res  = clamp_period(pm1, fast_q, slow_q);
    emit_inc = emit_q + STEP_W'(1);
    mag      = steps_q[STEP_W-1] ? (~steps_q + STEP_W'(1)) : steps_q;
    mn       = div_q[SPD_W-1:0];
    dspd     = (s_tp_q > mn) ? (s_tp_q - mn) : '0;
    delta    = (div_q > DVD_W'(DELTA_CAP)) ? DELTA_CAP : div_q[62:0];
    if (up_q) begin
      next_spd = 63'(s_cur_q) + delta;
    end else begin
      next_spd = (delta > 63'(s_cur_q)) ? '0 : (63'(s_cur_q) - delta);
    end
    hz       = next_spd[62:FRAC_W];
    spd_dvd  = DVD_W'({fc_q, {FRAC_W{1'b0}}});
    ramp_t   = (div_q > DVD_W'(16'hffff)) ? 16'hffff : div_q[RAMP_W-1:0];
    if (ramp_t > maxr_eff) ramp_t = maxr_eff;
    if (ramp_t == '0) ramp_t = RAMP_W'(1);
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; steps_d = steps_q; speed_d = speed_q; back_d = back_q;
    mode_d = mode_q; phase_d = phase_q; dir_d = dir_q; up_d = up_q;
    cur_d = cur_q; tp_d = tp_q; ramp_d = ramp_q;
    tgt_d = tgt_q; emit_d = emit_q; hold_d = hold_q;
    fc_d = fc_q; s_cur_d = s_cur_q; s_tp_d = s_tp_q; s_sp_d = s_sp_q;
    div_start = 1'b0;
    div_dvd = '0;
    div_dsr = '0;
    div_n = '0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i;
          steps_d = step_count_i;
          speed_d = speed_hz_i;
          back_d = run_backward_i;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        state_d = ST_OUT;
        div_dvd = DVD_W'(tclk_q);
        div_dsr = DSR_W'(pre_q) + DSR_W'(1);
        div_n = CNT_W'(CLK_W);
        if (cmd_q == CMD_STOP || (cmd_q == CMD_MOVE && steps_q == '0)) begin
          mode_d = MODE_STOP; phase_d = PHASE_UNSET; ramp_d = '0;
          hold_d = '0; up_d = 1'b1; tgt_d = '0; emit_d = '0;
        end else if (cmd_q == CMD_MOVE || cmd_q == CMD_RUN) begin
          if (cmd_q == CMD_MOVE) begin
            dir_d = steps_q[STEP_W-1];
            tgt_d = mag;
            emit_d = '0;
            mode_d = MODE_MOVE;
          end else begin
            dir_d = back_q;
            ramp_d = maxr_eff;
            mode_d = MODE_RUN;
          end
          cur_d = sp; phase_d = PHASE_ACCEL; hold_d = '0; up_d = 1'b1;
          div_start = 1'b1;
          state_d = ST_FC;
        end else if (mode_q == MODE_MOVE) begin
          emit_d = emit_inc;
          if (emit_inc >= tgt_q) begin
            mode_d = MODE_STOP; phase_d = PHASE_UNSET; ramp_d = '0;
            hold_d = '0; up_d = 1'b1; tgt_d = '0; emit_d = '0;
          end else if (phase_q == PHASE_ACCEL || phase_q == PHASE_DECEL) begin
            div_start = 1'b1;
            state_d = ST_FC;
          end else if (phase_q == PHASE_HOLD) begin
            if (up_q) begin
              if (emit_inc >= (tgt_q >> 1)) up_d = 1'b0;
              else hold_d = hold_q + STEP_W'(1);
            end else if (hold_q <= STEP_W'(1)) begin
              hold_d = '0;
              phase_d = PHASE_DECEL;
            end else begin
              hold_d = hold_q - STEP_W'(1);
            end
          end
        end else if (mode_q == MODE_RUN && phase_q == PHASE_ACCEL) begin
          div_start = 1'b1;
          state_d = ST_FC;
        end
      end
      ST_FC: begin
        if (div_done) begin
          fc_d = div_q[CLK_W-1:0];
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        div_start = 1'b1;
        div_dvd = spd_dvd;
        div_n = CNT_W'(SPD_W);
        if (cmd_q == CMD_TICK) begin
          div_dsr = DSR_W'(cur_q) + DSR_W'(1);
          state_d = ST_SCUR;
        end else if (speed_q != '0) begin
          div_dvd = DVD_W'(fc_q);
          div_dsr = DSR_W'(speed_q);
          div_n = CNT_W'(CLK_W);
          state_d = ST_TGT;
        end else begin
          tp_d = sp;
          div_dsr = DSR_W'(sp) + DSR_W'(1);
          div_start = (cmd_q == CMD_MOVE);
          state_d = (cmd_q == CMD_MOVE) ? ST_SSP : ST_OUT;
        end
      end
      ST_TGT: begin
        if (div_done) begin
          tp_d = per_res;
          div_start = (cmd_q == CMD_MOVE);
          div_dvd = spd_dvd;
          div_dsr = DSR_W'(sp) + DSR_W'(1);
          div_n = CNT_W'(SPD_W);
          state_d = (cmd_q == CMD_MOVE) ? ST_SSP : ST_OUT;
        end
      end
      ST_SSP: begin
        if (div_done) begin
          s_sp_d = div_q[SPD_W-1:0];
          div_start = 1'b1;
          div_dvd = spd_dvd;
          div_dsr = DSR_W'(tp_q) + DSR_W'(1);
          div_n = CNT_W'(SPD_W);
          state_d = ST_STP;
        end
      end
      ST_STP: begin
        if (div_done) begin
          s_tp_d = div_q[SPD_W-1:0];
          div_start = 1'b1;
          div_dvd = DVD_W'(57'(tgt_q) * 57'(RAMP_NUM));
          div_dsr = DSR_W'(s_sp_q) + DSR_W'(div_q[SPD_W-1:0]);
          div_n = CNT_W'(57);
          state_d = ST_RAMP;
        end
      end
      ST_RAMP: begin
        if (div_done) begin
          ramp_d = ramp_t;
          state_d = ST_OUT;
        end
      end
      ST_SCUR: begin
        if (div_done) begin
          s_cur_d = div_q[SPD_W-1:0];
          div_start = 1'b1;
          div_dvd = spd_dvd;
          div_dsr = DSR_W'(tp_q) + DSR_W'(1);
          div_n = CNT_W'(SPD_W);
          state_d = ST_STAR;
        end
      end
      ST_STAR: begin
        if (div_done) begin
          s_tp_d = div_q[SPD_W-1:0];
          div_start = 1'b1;
          div_dvd = spd_dvd;
          div_dsr = DSR_W'(sp) + DSR_W'(1);
          div_n = CNT_W'(SPD_W);
          state_d = ST_SMIN;
        end
      end
      ST_SMIN: begin
        if (div_done) begin
          div_dvd = DVD_W'(54'(dspd) * 54'(RATE_SCALE));
          div_dsr = DSR_W'(rt);
          div_n = CNT_W'(54);
          state_d = ST_OUT;
          if (phase_q == PHASE_ACCEL) begin
            up_d = 1'b1;
            if (s_cur_q <= s_tp_q) begin
              div_start = 1'b1;
              state_d = ST_T1;
            end else begin
              phase_d = PHASE_HOLD; cur_d = tp_q; hold_d = '0;
            end
          end else begin
            up_d = 1'b0;
            if (s_cur_q >= mn) begin
              div_start = 1'b1;
              state_d = ST_T1;
            end else begin
              phase_d = PHASE_UNSET; cur_d = sp; up_d = 1'b1;
            end
          end
        end
      end
      ST_T1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd = DVD_W'({div_q[53:0], {FRAC_W{1'b0}}});
          div_dsr = DSR_W'(s_cur_q);
          div_n = CNT_W'(70);
          state_d = ST_DELTA;
        end
      end
      ST_DELTA: begin
        if (div_done) begin
          up_d = 1'b1;
          if (hz == '0) begin
            cur_d = sp;
            state_d = ST_OUT;
          end else begin
            div_start = 1'b1;
            div_dvd = DVD_W'(fc_q);
            div_dsr = DSR_W'(hz);
            div_n = CNT_W'(CLK_W);
            state_d = ST_PER;
          end
        end
      end
      ST_PER: begin
        if (div_done) begin
          cur_d = per_res;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free_i) begin
          res_valid_o = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tclk_q <= CLK_W'(168000000);
      pre_q <= PRE_W'(13);
      maxr_q <= RAMP_W'(500);
      fwd_q <= 1'b1;
      fast_q <= PER_W'(2);
      slow_q <= PER_W'(65535);
      mode_q <= MODE_STOP;
      phase_q <= PHASE_UNSET;
      dir_q <= 1'b0;
      up_q <= 1'b1;
      cur_q <= PER_W'(65535);
      tp_q <= '0;
      ramp_q <= '0;
      tgt_q <= '0;
      emit_q <= '0;
      hold_q <= '0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      phase_q <= phase_d;
      dir_q <= dir_d;
      up_q <= up_d;
      cur_q <= cur_d;
      tp_q <= tp_d;
      ramp_q <= ramp_d;
      tgt_q <= tgt_d;
      emit_q <= emit_d;
      hold_q <= hold_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TCLK: tclk_q <= cfg_wdata_i;
          CFG_PRE:  pre_q <= cfg_wdata_i[PRE_W-1:0];
          CFG_RAMP: maxr_q <= cfg_wdata_i[RAMP_W-1:0];
          CFG_FWD:  fwd_q <= cfg_wdata_i[0];
          CFG_FAST: fast_q <= cfg_wdata_i[PER_W-1:0];
          CFG_SLOW: slow_q <= cfg_wdata_i[PER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    steps_q <= steps_d;
    speed_q <= speed_d;
    back_q <= back_d;
    fc_q <= fc_d;
    s_cur_q <= s_cur_d;
    s_tp_q <= s_tp_d;
    s_sp_q <= s_sp_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign res_o.period  = cur_q;
  assign res_o.compare = cur_q[PER_W-1:1];
  assign res_o.dir     = dir_q ^ fwd_q;
  assign res_o.pen     = (mode_q != MODE_STOP);
  assign res_o.mode    = mode_q;
  assign res_o.phase   = phase_q;

endmodule

// ===== hw/rtl/stepper_trapezoid_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp unit
// Pulse-rate profiler with a registered result word.
// ----------------------------------------------------------------------------
// A move, run or ramp tick is worked out by the bit-serial divider, which retires
// one quotient bit per cycle; a stop, idle or hold tick is registered with no division.
// One word is in work at a time; the next word is accepted once the result is
// registered, and a result still waiting at the output holds the next.
// Reset returns the core to idle, resets the motion state and the output valid flag
// and loads the default configuration at once; the result word itself is not reset.
`timescale 1ns / 1ps

module stepper_trapezoid_ramp_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [str_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [str_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [str_pkg::STEP_W-1:0]     step_count_i,
  input  logic [str_pkg::CLK_W-1:0]      speed_hz_i,
  input  logic                           run_backward_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [str_pkg::PER_W-1:0]      period_value_o,
  output logic [str_pkg::PER_W-2:0]      compare_value_o,
  output logic                           dir_level_o,
  output logic                           pulse_enable_o,
  output logic [1:0]                     run_mode_o,
  output logic [1:0]                     ramp_phase_o
);
  import str_pkg::*;
  `include "assert_macros.svh"

  logic out_valid_q;
  res_t res_q;
  res_t core_res;
  logic core_valid;
  logic slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  str_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .step_count_i   (step_count_i),
    .speed_hz_i     (speed_hz_i),
    .run_backward_i (run_backward_i),
    .slot_free_i    (slot_free),
    .res_valid_o    (core_valid),
    .res_o          (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign period_value_o  = res_q.period;
  assign compare_value_o = res_q.compare;
  assign dir_level_o     = res_q.dir;
  assign pulse_enable_o  = res_q.pen;
  assign run_mode_o      = res_q.mode;
  assign ramp_phase_o    = res_q.phase;

  `ASSERT_IMPLIES(a_pen_mode, out_valid_o, pulse_enable_o == (run_mode_o != MODE_STOP))
  `ASSERT_IMPLIES(a_stop_phase, out_valid_o && run_mode_o == MODE_STOP, ramp_phase_o == PHASE_UNSET)
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

endmodule
